// ===== design/rcwq_pkg.sv =====
package rcwq_pkg;

	// Operation codes carried in the kind field.
	localparam logic [2:0] OP_REQUEST = 3'd0;
	localparam logic [2:0] OP_RELEASE = 3'd1;
	localparam logic [2:0] OP_PUSH    = 3'd2;
	localparam logic [2:0] OP_POP     = 3'd3;
	localparam logic [2:0] OP_HEAD    = 3'd4;
	localparam logic [2:0] OP_REINIT  = 3'd5;

	// Status codes returned with every result.
	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_BAD_INDEX   = 3'd1;
	localparam logic [2:0] ST_ABOVE_TOTAL = 3'd2;
	localparam logic [2:0] ST_SHORT       = 3'd3;
	localparam logic [2:0] ST_EMPTY       = 3'd4;
	localparam logic [2:0] ST_FULL        = 3'd5;

	// Field widths of one request and one result.
	localparam int KIND_W  = 3;
	localparam int RID_W   = 4;
	localparam int CNT_W   = 4;
	localparam int PID_W   = 8;
	localparam int FREE_W  = 8;
	localparam int ENTRY_W = PID_W + CNT_W;

	// One request as held in the first stage.
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [RID_W-1:0]  resource_index;
		logic [CNT_W-1:0]  unit_count;
		logic [PID_W-1:0]  process_id;
	} req_t;

	// One result as held in the output register.
	typedef struct packed {
		logic [2:0]        status;
		logic [PID_W-1:0]  head_process;
		logic [CNT_W-1:0]  head_count;
		logic [FREE_W-1:0] free_units;
	} result_t;

endpackage

// ===== design/rcwq_store.sv =====
// Waiter memory: one write port and one registered read port. A read that
// meets a write to the same entry in the same cycle returns the new data.
module rcwq_store #(
	parameter int DEPTH  = 32,
	parameter int ADDR_W = 5
) (
	input  logic                         clk,
	input  logic                         wr_en,
	input  logic [ADDR_W-1:0]            wr_addr,
	input  logic [rcwq_pkg::ENTRY_W-1:0] wr_data,
	input  logic                         rd_en,
	input  logic [ADDR_W-1:0]            rd_addr,
	output logic [rcwq_pkg::ENTRY_W-1:0] rd_data_s1
);

	logic [rcwq_pkg::ENTRY_W-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port, loaded as a request enters the first stage.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_data_s1 <= wr_data;
			end else begin
				rd_data_s1 <= mem[rd_addr];
			end
		end
	end

endmodule

// ===== design/rcwq_ctrl.sv =====
// Counter and queue pointer state, and the single-pass logic that works out
// one request from the first stage into a result and the next state.
module rcwq_ctrl #(
	parameter int NUM_RESOURCES = 4,
	parameter int QUEUE_DEPTH   = 8,
	parameter int ADDR_W        = 5
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         fire,
	input  rcwq_pkg::req_t               req_s1,
	input  logic [rcwq_pkg::ENTRY_W-1:0] rd_data_s1,
	input  logic [rcwq_pkg::RID_W-1:0]   rd_rid,
	output logic [ADDR_W-1:0]            rd_addr,
	output logic                         wr_en,
	output logic [ADDR_W-1:0]            wr_addr,
	output logic [rcwq_pkg::ENTRY_W-1:0] wr_data,
	output rcwq_pkg::result_t            res
);

	localparam int RES_IW = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
	localparam int PTR_W  = $clog2(QUEUE_DEPTH);
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
	localparam int FREE_W = rcwq_pkg::FREE_W;
	localparam int CNT_W  = rcwq_pkg::CNT_W;
	localparam int RID_W  = rcwq_pkg::RID_W;

	logic [FREE_W-1:0] free_q [NUM_RESOURCES];
	logic [PTR_W-1:0]  head_q [NUM_RESOURCES];
	logic [PTR_W-1:0]  tail_q [NUM_RESOURCES];
	logic [FILL_W-1:0] fill_q [NUM_RESOURCES];
	logic [FREE_W-1:0] free_d [NUM_RESOURCES];
	logic [PTR_W-1:0]  head_d [NUM_RESOURCES];
	logic [PTR_W-1:0]  tail_d [NUM_RESOURCES];
	logic [FILL_W-1:0] fill_d [NUM_RESOURCES];

	logic              good;
	logic [RES_IW-1:0] ridx;
	logic [RES_IW-1:0] rd_ridx;
	logic [FREE_W-1:0] cur_free;
	logic [FILL_W-1:0] cur_fill;
	logic [FREE_W:0]   rel_sum;
	logic              push_ok;
	logic [PTR_W-1:0]  rd_head;

	// Wrap a queue pointer at the end of its ring.
	function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] n;
		n = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
		return n;
	endfunction

	// Flat memory address of one queue slot.
	function automatic logic [ADDR_W-1:0] slot_addr(input logic [RES_IW-1:0] r,
			input logic [PTR_W-1:0] p);
		logic [ADDR_W-1:0] a;
		a = ADDR_W'(ADDR_W'(r) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(p));
		return a;
	endfunction

	assign good     = {1'b0, req_s1.resource_index} < (RID_W + 1)'(NUM_RESOURCES);
	assign ridx     = req_s1.resource_index[RES_IW-1:0];
	assign cur_free = free_q[ridx];
	assign cur_fill = fill_q[ridx];
	assign rel_sum  = {1'b0, cur_free} + (FREE_W + 1)'(req_s1.unit_count);

	// Work out the result and the next state of one request.
	always_comb begin
		free_d  = free_q;
		head_d  = head_q;
		tail_d  = tail_q;
		fill_d  = fill_q;
		push_ok = 1'b0;
		res     = '0;
		res.status = rcwq_pkg::ST_OK;
		if (req_s1.kind == rcwq_pkg::OP_REINIT) begin
			for (int i = 0; i < NUM_RESOURCES; i++) begin
				free_d[i] = FREE_W'(i + 1);
				head_d[i] = '0;
				tail_d[i] = '0;
				fill_d[i] = '0;
			end
		end else if (!good) begin
			res.status = rcwq_pkg::ST_BAD_INDEX;
		end else begin
			case (req_s1.kind)
				rcwq_pkg::OP_REQUEST: begin
					if ({1'b0, req_s1.unit_count} >
							(CNT_W + 1)'(req_s1.resource_index) + 1'b1) begin
						res.status = rcwq_pkg::ST_ABOVE_TOTAL;
					end else if (cur_free < FREE_W'(req_s1.unit_count)) begin
						res.status = rcwq_pkg::ST_SHORT;
					end else begin
						free_d[ridx] = cur_free - FREE_W'(req_s1.unit_count);
					end
				end
				rcwq_pkg::OP_RELEASE: begin
					free_d[ridx] = rel_sum[FREE_W] ? '1 : rel_sum[FREE_W-1:0];
				end
				rcwq_pkg::OP_PUSH: begin
					if (cur_fill == FILL_W'(QUEUE_DEPTH)) begin
						res.status = rcwq_pkg::ST_FULL;
					end else begin
						push_ok      = 1'b1;
						tail_d[ridx] = next_slot(tail_q[ridx]);
						fill_d[ridx] = cur_fill + 1'b1;
					end
				end
				rcwq_pkg::OP_POP: begin
					if (cur_fill == '0) begin
						res.status = rcwq_pkg::ST_EMPTY;
					end else begin
						head_d[ridx] = next_slot(head_q[ridx]);
						fill_d[ridx] = cur_fill - 1'b1;
					end
				end
				rcwq_pkg::OP_HEAD: begin
					if (cur_fill == '0) begin
						res.status = rcwq_pkg::ST_EMPTY;
					end else begin
						res.head_process = rd_data_s1[rcwq_pkg::ENTRY_W-1:CNT_W];
						res.head_count   = rd_data_s1[CNT_W-1:0];
					end
				end
				default: begin
					res.status = rcwq_pkg::ST_OK;
				end
			endcase
		end
		res.free_units = good ? free_d[ridx] : '0;
	end

	// Waiter write for a push that goes ahead.
	assign wr_en   = fire && push_ok;
	assign wr_addr = slot_addr(ridx, tail_q[ridx]);
	assign wr_data = {req_s1.process_id, req_s1.unit_count};

	// Head read for the incoming request sees the pointer this request leaves.
	assign rd_ridx = rd_rid[RES_IW-1:0];
	assign rd_head = fire ? head_d[rd_ridx] : head_q[rd_ridx];
	assign rd_addr = slot_addr(rd_ridx, rd_head);

	// State registers, updated once per request as it leaves the first stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_RESOURCES; i++) begin
				free_q[i] <= FREE_W'(i + 1);
				head_q[i] <= '0;
				tail_q[i] <= '0;
				fill_q[i] <= '0;
			end
		end else if (fire) begin
			free_q <= free_d;
			head_q <= head_d;
			tail_q <= tail_d;
			fill_q <= fill_d;
		end
	end

endmodule

// ===== design/resource_counter_wait_queues_core.sv =====
// Counting semaphores with a wait queue per resource kind. Kind i owns i+1
// units and a ring of QUEUE_DEPTH waiters; every request (take, give back,
// push waiter, pop head, read head, reinitialise) gives one result. A request
// enters an input register, is worked out in one pass against the counters
// and queue pointers, and its result lands in an output register as the
// request leaves the input register, so one request is taken every cycle
// while the output side keeps up. The waiter memory is read as a request is
// accepted, with the pointer and data left by the request ahead of it
// forwarded, so back-to-back requests on the same queue need no bubble. The
// memory is not cleared; queue fill counts guard it, so no clearing pass
// follows reset.
module resource_counter_wait_queues_core #(
	parameter int NUM_RESOURCES = 4,
	parameter int QUEUE_DEPTH   = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [rcwq_pkg::KIND_W-1:0] kind,
	input  logic [rcwq_pkg::RID_W-1:0]  resource_index,
	input  logic [rcwq_pkg::CNT_W-1:0]  unit_count,
	input  logic [rcwq_pkg::PID_W-1:0]  process_id,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [2:0]                  status,
	output logic [rcwq_pkg::PID_W-1:0]  head_process,
	output logic [rcwq_pkg::CNT_W-1:0]  head_count,
	output logic [rcwq_pkg::FREE_W-1:0] free_units
);

	localparam int MEM_DEPTH = NUM_RESOURCES * QUEUE_DEPTH;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);

	logic                         valid_s1;
	rcwq_pkg::req_t               req_s1;
	logic                         out_valid_q;
	rcwq_pkg::result_t            result_q;
	rcwq_pkg::result_t            res;
	logic                         fire;
	logic                         accept;
	logic [ADDR_W-1:0]            rd_addr;
	logic                         wr_en;
	logic [ADDR_W-1:0]            wr_addr;
	logic [rcwq_pkg::ENTRY_W-1:0] wr_data;
	logic [rcwq_pkg::ENTRY_W-1:0] rd_data_s1;

	// Handshake: the first stage moves on whenever the output register is free.
	assign fire     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || fire;
	assign accept   = in_valid && in_ready;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= '{kind: kind, resource_index: resource_index,
				unit_count: unit_count, process_id: process_id};
		end
	end

	rcwq_ctrl #(
		.NUM_RESOURCES (NUM_RESOURCES),
		.QUEUE_DEPTH   (QUEUE_DEPTH),
		.ADDR_W        (ADDR_W)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.req_s1     (req_s1),
		.rd_data_s1 (rd_data_s1),
		.rd_rid     (resource_index),
		.rd_addr    (rd_addr),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.res        (res)
	);

	rcwq_store #(
		.DEPTH  (MEM_DEPTH),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk        (clk),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.rd_en      (accept),
		.rd_addr    (rd_addr),
		.rd_data_s1 (rd_data_s1)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = result_q.status;
	assign head_process = result_q.head_process;
	assign head_count   = result_q.head_count;
	assign free_units   = result_q.free_units;

endmodule
